@@ design/depth_pixel_stability_filter_unit_assert.svh @@
// assertion macros for the depth pixel stability filter
`ifndef DEPTH_PIXEL_STABILITY_FILTER_UNIT_ASSERT_SVH
`define DEPTH_PIXEL_STABILITY_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DPSF_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication, checked out of reset
`define DPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dpsf_pkg.sv @@
package dpsf_pkg;

    localparam int FRAME_PIXELS = 307200;
    localparam int FRAC_BITS    = 8;
    localparam int IDX_W        = 19;
    localparam int DEPTH_W      = 16;
    localparam int LEVEL_W      = 8;
    localparam int WEIGHT_W     = 9;
    localparam int THR_W        = 8;
    localparam int CNT_W        = 10;
    localparam int AVG_W        = LEVEL_W + FRAC_BITS;
    localparam int NUM_W        = 25;
    localparam int DEN_W        = DEPTH_W + 1;
    localparam int DIV_STAGES   = LEVEL_W;
    localparam int NORM_SCALE   = 510;
    localparam int LEVEL_MAX    = 255;
    localparam int SHOW_MARGIN  = 3;
    localparam int WEIGHT_ONE   = 256;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_MIN,
        REG_DEPTH_MAX,
        REG_SLOW_WEIGHT,
        REG_FAST_WEIGHT,
        REG_CHANGE_THRESHOLD,
        REG_MIN_STABILITY
    } cfg_reg_e;

    typedef struct packed {
        logic [DEPTH_W-1:0]  depth_min;
        logic [DEPTH_W-1:0]  depth_max;
        logic [WEIGHT_W-1:0] slow_weight;
        logic [WEIGHT_W-1:0] fast_weight;
        logic [THR_W-1:0]    change_threshold;
        logic [CNT_W-1:0]    min_stability;
    } cfg_t;

    typedef struct packed {
        logic [AVG_W-1:0]   slow_avg;
        logic [AVG_W-1:0]   fast_avg;
        logic [CNT_W-1:0]   count;
        logic [LEVEL_W-1:0] held;
    } pix_state_t;

    localparam int STATE_W = $bits(pix_state_t);

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   pixel_index;
        logic [LEVEL_W-1:0] norm_level;
    } norm_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] norm_level;
        logic               changing;
        logic [CNT_W-1:0]   stable_frames;
        logic               shown;
        logic [LEVEL_W-1:0] final_level;
    } result_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
    } clear_t;

endpackage

@@ design/dpsf_if.sv @@
interface dpsf_sample_if;
    logic                          valid;
    logic                          ready;
    logic [dpsf_pkg::DEPTH_W-1:0]  depth_mm;
    logic [dpsf_pkg::IDX_W-1:0]    pixel_index;

    modport source (output valid, depth_mm, pixel_index, input ready);
    modport sink   (input valid, depth_mm, pixel_index, output ready);
endinterface

interface dpsf_result_if;
    logic                          valid;
    logic                          ready;
    logic [dpsf_pkg::LEVEL_W-1:0]  norm_level;
    logic                          changing;
    logic [dpsf_pkg::CNT_W-1:0]    stable_frames;
    logic                          shown;
    logic [dpsf_pkg::LEVEL_W-1:0]  final_level;

    modport source (output valid, norm_level, changing, stable_frames, shown, final_level,
                    input ready);
    modport sink   (input valid, norm_level, changing, stable_frames, shown, final_level,
                    output ready);
endinterface

@@ design/dpsf_ram.sv @@
module dpsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/dpsf_norm.sv @@
module dpsf_norm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic [dpsf_pkg::DEPTH_W-1:0] depth_mm,
    input  logic [dpsf_pkg::IDX_W-1:0]   pixel_index,
    input  dpsf_pkg::cfg_t               cfg,
    output dpsf_pkg::norm_item_t         item
);

    localparam int N = dpsf_pkg::DIV_STAGES;

    logic [N:0]                      vld_reg;
    logic [dpsf_pkg::IDX_W-1:0]      idx_reg [0:N];
    logic                            ok_reg  [0:N];
    logic [dpsf_pkg::NUM_W-1:0]      rem_reg [0:N];
    logic [dpsf_pkg::DEN_W-1:0]      den_reg [0:N];
    logic [dpsf_pkg::LEVEL_W-1:0]    q_reg   [0:N];

    logic                            pre_ok;
    logic [dpsf_pkg::DEPTH_W-1:0]    pre_range;
    logic [dpsf_pkg::DEPTH_W-1:0]    pre_offs;
    logic [dpsf_pkg::NUM_W-1:0]      pre_num;
    logic [dpsf_pkg::NUM_W-1:0]      dsh [0:N-1];
    logic                            ge  [0:N-1];

    // range check and scaled numerator
    always_comb
    begin
        pre_ok    = (cfg.depth_max > cfg.depth_min) && (depth_mm >= cfg.depth_min)
                    && (depth_mm <= cfg.depth_max);
        pre_range = dpsf_pkg::DEPTH_W'(cfg.depth_max - cfg.depth_min);
        pre_offs  = dpsf_pkg::DEPTH_W'(depth_mm - cfg.depth_min);
        pre_num   = dpsf_pkg::NUM_W'(pre_offs) * dpsf_pkg::NUM_W'(dpsf_pkg::NORM_SCALE)
                    + dpsf_pkg::NUM_W'(pre_range);
    end

    // one quotient bit per stage, msb first
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            dsh[i] = dpsf_pkg::NUM_W'(den_reg[i]) << (N - 1 - i);
            ge[i]  = rem_reg[i] >= dsh[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_reg[0] <= pixel_index;
            ok_reg[0]  <= pre_ok;
            rem_reg[0] <= pre_num;
            den_reg[0] <= {pre_range, 1'b0};
            q_reg[0]   <= '0;
            for (int i = 0; i < N; i++)
            begin
                idx_reg[i+1] <= idx_reg[i];
                ok_reg[i+1]  <= ok_reg[i];
                den_reg[i+1] <= den_reg[i];
                rem_reg[i+1] <= ge[i] ? dpsf_pkg::NUM_W'(rem_reg[i] - dsh[i]) : rem_reg[i];
                q_reg[i+1]   <= {q_reg[i][dpsf_pkg::LEVEL_W-2:0], ge[i]};
            end
        end
    end

    always_comb
    begin
        item.valid       = vld_reg[N];
        item.pixel_index = idx_reg[N];
        if (ok_reg[N] && (q_reg[N] != '0))
        begin
            item.norm_level = dpsf_pkg::LEVEL_W'(dpsf_pkg::LEVEL_MAX) - q_reg[N];
        end
        else
        begin
            item.norm_level = '0;
        end
    end

endmodule

@@ design/dpsf_update.sv @@
module dpsf_update (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  dpsf_pkg::norm_item_t item,
    input  dpsf_pkg::cfg_t       cfg,
    input  dpsf_pkg::clear_t     clear,
    output logic                 out_valid,
    output dpsf_pkg::result_t    out_data
);

    localparam int AW = dpsf_pkg::AVG_W;
    localparam int PW = AW + dpsf_pkg::WEIGHT_W;
    localparam int SW = PW + 1;

    logic                         x_vld_reg;
    logic [dpsf_pkg::IDX_W-1:0]   x_idx_reg;
    logic [dpsf_pkg::LEVEL_W-1:0] x_level_reg;
    logic                         byp_hit_reg;
    dpsf_pkg::pix_state_t         byp_state_reg;
    logic                         out_valid_reg;
    dpsf_pkg::result_t            out_reg;

    logic [dpsf_pkg::STATE_W-1:0] ram_rd;
    logic                         ram_we;
    logic [dpsf_pkg::IDX_W-1:0]   ram_waddr;
    logic [dpsf_pkg::STATE_W-1:0] ram_wdata;

    dpsf_pkg::pix_state_t         old_st;
    dpsf_pkg::pix_state_t         new_st;
    dpsf_pkg::result_t            res;
    logic                         in_frame;
    logic [dpsf_pkg::WEIGHT_W-1:0] ws;
    logic [dpsf_pkg::WEIGHT_W-1:0] wf;
    logic [AW-1:0]                x_avg;
    logic [SW-1:0]                s_acc;
    logic [SW-1:0]                f_acc;
    logic [AW-1:0]                s_blend;
    logic [AW-1:0]                f_blend;
    logic [AW-1:0]                diff;
    logic                         chg;
    logic [dpsf_pkg::CNT_W:0]     show_sum;
    logic [AW:0]                  round_sum;
    logic [dpsf_pkg::LEVEL_W-1:0] rounded;

    dpsf_ram #(
        .WIDTH (dpsf_pkg::STATE_W),
        .DEPTH (dpsf_pkg::FRAME_PIXELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (advance),
        .rd_addr (item.pixel_index),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        old_st   = byp_hit_reg ? byp_state_reg : dpsf_pkg::pix_state_t'(ram_rd);
        in_frame = x_idx_reg < dpsf_pkg::IDX_W'(dpsf_pkg::FRAME_PIXELS);
        // weights above one act as one
        ws = cfg.slow_weight[dpsf_pkg::WEIGHT_W-1]
             ? dpsf_pkg::WEIGHT_W'(dpsf_pkg::WEIGHT_ONE) : cfg.slow_weight;
        wf = cfg.fast_weight[dpsf_pkg::WEIGHT_W-1]
             ? dpsf_pkg::WEIGHT_W'(dpsf_pkg::WEIGHT_ONE) : cfg.fast_weight;
        x_avg = {x_level_reg, {dpsf_pkg::FRAC_BITS{1'b0}}};

        s_acc = SW'(PW'(old_st.slow_avg) * PW'(dpsf_pkg::WEIGHT_W'(dpsf_pkg::WEIGHT_ONE) - ws))
                + SW'(PW'(x_avg) * PW'(ws)) + SW'(1 << 7);
        f_acc = SW'(PW'(old_st.fast_avg) * PW'(dpsf_pkg::WEIGHT_W'(dpsf_pkg::WEIGHT_ONE) - wf))
                + SW'(PW'(x_avg) * PW'(wf)) + SW'(1 << 7);
        s_blend = s_acc[AW+7:8];
        f_blend = f_acc[AW+7:8];
        diff    = (s_blend > f_blend) ? AW'(s_blend - f_blend) : AW'(f_blend - s_blend);
        chg     = diff > {cfg.change_threshold, {dpsf_pkg::FRAC_BITS{1'b0}}};

        new_st = old_st;
        new_st.fast_avg = f_blend;
        if (chg)
        begin
            new_st.count    = '0;
            new_st.slow_avg = x_avg;
        end
        else
        begin
            new_st.slow_avg = s_blend;
            if (old_st.count < cfg.min_stability)
            begin
                new_st.count = dpsf_pkg::CNT_W'(old_st.count + 1'b1);
            end
        end
        show_sum  = (dpsf_pkg::CNT_W+1)'(new_st.count)
                    + (dpsf_pkg::CNT_W+1)'(dpsf_pkg::SHOW_MARGIN);
        round_sum = (AW+1)'(new_st.slow_avg) + (AW+1)'(1 << (dpsf_pkg::FRAC_BITS - 1));
        rounded   = round_sum[AW] ? dpsf_pkg::LEVEL_W'(dpsf_pkg::LEVEL_MAX)
                                  : round_sum[AW-1:dpsf_pkg::FRAC_BITS];
        if (show_sum >= (dpsf_pkg::CNT_W+1)'(cfg.min_stability))
        begin
            new_st.held = rounded;
        end

        res.norm_level = x_level_reg;
        if (in_frame)
        begin
            res.changing      = chg;
            res.stable_frames = new_st.count;
            res.shown         = show_sum >= (dpsf_pkg::CNT_W+1)'(cfg.min_stability);
            res.final_level   = new_st.held;
        end
        else
        begin
            res.changing      = 1'b0;
            res.stable_frames = '0;
            res.shown         = 1'b0;
            res.final_level   = '0;
        end

        // clear sweep owns the write port while it runs
        ram_we    = clear.we || (advance && x_vld_reg && in_frame);
        ram_waddr = clear.we ? clear.addr : x_idx_reg;
        ram_wdata = clear.we ? '0 : new_st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end
        else if (advance)
        begin
            x_vld_reg     <= item.valid;
            out_valid_reg <= x_vld_reg;
            // same-edge write and read of one pixel: ram returns old data
            byp_hit_reg   <= x_vld_reg && in_frame && (x_idx_reg == item.pixel_index);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_idx_reg     <= item.pixel_index;
            x_level_reg   <= item.norm_level;
            byp_state_reg <= new_st;
            out_reg       <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ design/depth_pixel_stability_filter_unit.sv @@
// depth pixel stability filter
// sample channel: one depth sample (mm) and its pixel index per transaction
// result channel: one transaction per sample, in order: inverted 8-bit level,
//   changing flag, stability count, shown flag and the pixel's held level
// cfg port: write enable, register index, 16-bit data; write only while idle
// latency: 10 cycles from sample acceptance to result valid
//   offset scaling in the accept cycle, 8 cycles of a one-bit-per-stage divider,
//   1 cycle state read, 1 cycle blend and writeback into the result register
// throughput: one sample per cycle; a pixel hit twice in a row is handled by
//   a bypass of the state just written, so no bubble is needed
// reset: config returns to its defaults, then a clear pass writes zero state to
//   all 307200 pixels, one per cycle; sample ready stays low for those cycles
// stall: while the result is held and not taken, the whole pipeline freezes,
//   ready drops and no transaction is lost or repeated; a taken result frees a
//   slot in the same cycle so a new sample can enter
// pixel indexes past the frame leave state untouched and return zero fields
module depth_pixel_stability_filter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dpsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpsf_pkg::CFG_DATA_W-1:0] cfg_data,
    dpsf_sample_if.sink                     sample,
    dpsf_result_if.source                   result
);

    dpsf_pkg::cfg_t            cfg_reg;
    logic                      clear_busy_reg;
    logic [dpsf_pkg::IDX_W-1:0] clr_addr_reg;
    logic                      advance;
    dpsf_pkg::norm_item_t      item;
    dpsf_pkg::clear_t          clear;
    logic                      out_valid;
    dpsf_pkg::result_t         out_data;

    // pipeline moves when the result register is empty or being taken
    assign advance      = !out_valid || result.ready;
    assign sample.ready = advance && !clear_busy_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_min        <= dpsf_pkg::DEPTH_W'(500);
            cfg_reg.depth_max        <= dpsf_pkg::DEPTH_W'(1000);
            cfg_reg.slow_weight      <= dpsf_pkg::WEIGHT_W'(13);
            cfg_reg.fast_weight      <= dpsf_pkg::WEIGHT_W'(205);
            cfg_reg.change_threshold <= dpsf_pkg::THR_W'(1);
            cfg_reg.min_stability    <= dpsf_pkg::CNT_W'(15);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpsf_pkg::REG_DEPTH_MIN:
                begin
                    cfg_reg.depth_min <= cfg_data;
                end
                dpsf_pkg::REG_DEPTH_MAX:
                begin
                    cfg_reg.depth_max <= cfg_data;
                end
                dpsf_pkg::REG_SLOW_WEIGHT:
                begin
                    cfg_reg.slow_weight <= cfg_data[dpsf_pkg::WEIGHT_W-1:0];
                end
                dpsf_pkg::REG_FAST_WEIGHT:
                begin
                    cfg_reg.fast_weight <= cfg_data[dpsf_pkg::WEIGHT_W-1:0];
                end
                dpsf_pkg::REG_CHANGE_THRESHOLD:
                begin
                    cfg_reg.change_threshold <= cfg_data[dpsf_pkg::THR_W-1:0];
                end
                dpsf_pkg::REG_MIN_STABILITY:
                begin
                    cfg_reg.min_stability <= cfg_data[dpsf_pkg::CNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // clear pass over the state memory after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clear_busy_reg)
        begin
            clr_addr_reg <= dpsf_pkg::IDX_W'(clr_addr_reg + 1'b1);
            if (clr_addr_reg == dpsf_pkg::IDX_W'(dpsf_pkg::FRAME_PIXELS - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    assign clear.we   = clear_busy_reg;
    assign clear.addr = clr_addr_reg;

    // divider pipeline producing the inverted level
    dpsf_norm u_norm (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (sample.valid && sample.ready),
        .depth_mm    (sample.depth_mm),
        .pixel_index (sample.pixel_index),
        .cfg         (cfg_reg),
        .item        (item)
    );

    // per-pixel state update and result register
    dpsf_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .cfg       (cfg_reg),
        .clear     (clear),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign result.valid         = out_valid;
    assign result.norm_level    = out_data.norm_level;
    assign result.changing      = out_data.changing;
    assign result.stable_frames = out_data.stable_frames;
    assign result.shown         = out_data.shown;
    assign result.final_level   = out_data.final_level;

`include "depth_pixel_stability_filter_unit_assert.svh"

    `DPSF_ASSERT_NOW(a_no_accept_in_clear, (clear_busy_reg |-> !sample.ready), "sample taken during clear")
    `DPSF_ASSERT_NOW(a_chg_zero_count, (result.valid && result.changing |-> result.stable_frames == '0), "changing pixel kept count")
    `DPSF_ASSERT_NOW(a_level_below_max, (result.valid |-> result.norm_level != 8'hFF), "level reached full scale")
    `DPSF_ASSERT_NEXT(a_clear_once, !clear_busy_reg, !clear_busy_reg, "clear pass restarted")

endmodule

@@ dv/depth_pixel_stability_filter_unit_test.sv @@
`timescale 1ns / 100ps

module depth_pixel_stability_filter_unit_test;

    localparam logic [dpsf_pkg::CFG_IDX_W-1:0] REG_UNUSED =
        dpsf_pkg::CFG_IDX_W'(dpsf_pkg::REG_MIN_STABILITY) + 1'b1;
    localparam int SETTLE_CYCLES = 16;  // pipeline latency plus margin
    localparam int IDX_SPAN = 1 << dpsf_pkg::IDX_W;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [dpsf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dpsf_pkg::CFG_DATA_W-1:0] cfg_data;

    dpsf_sample_if sample ();
    dpsf_result_if result ();

    depth_pixel_stability_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample.sink),
        .result    (result.source)
    );

    // clock, 10 ns period
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // shadow configuration
    bit [dpsf_pkg::DEPTH_W-1:0]  range_lo;
    bit [dpsf_pkg::DEPTH_W-1:0]  range_hi;
    bit [dpsf_pkg::WEIGHT_W-1:0] slow_w;
    bit [dpsf_pkg::WEIGHT_W-1:0] fast_w;
    bit [dpsf_pkg::THR_W-1:0]    thresh;
    bit [dpsf_pkg::CNT_W-1:0]    stab_limit;

    // shadow per-pixel state, absent entries read as zero
    bit [dpsf_pkg::AVG_W-1:0]   slow_mem [int];
    bit [dpsf_pkg::AVG_W-1:0]   fast_mem [int];
    bit [dpsf_pkg::CNT_W-1:0]   count_mem [int];
    bit [dpsf_pkg::LEVEL_W-1:0] held_mem [int];

    dpsf_pkg::result_t pending_results[$];

    int error_count;
    int sent_count;
    int checked_count;
    int changing_seen;
    int shown_seen;
    int outside_seen;

    // sender burst control
    int burst_left;
    bit no_gaps;

    // receiver control
    int hold_cycles;
    int stall_mode;
    int mode_left;

    // inverted 8-bit level, zero when out of range or the top value
    function automatic bit [dpsf_pkg::LEVEL_W-1:0] depth_to_level(
        input bit [dpsf_pkg::DEPTH_W-1:0] d);
        bit [31:0] span;
        bit [31:0] v;
        if (range_hi <= range_lo || d < range_lo || d > range_hi)
            return '0;
        span = range_hi - range_lo;
        v = ((d - range_lo) * dpsf_pkg::NORM_SCALE + span) / (2 * span);
        if (v == 0 || v > dpsf_pkg::LEVEL_MAX)
            return '0;
        return dpsf_pkg::LEVEL_W'(dpsf_pkg::LEVEL_MAX - v);
    endfunction

    function automatic bit [dpsf_pkg::AVG_W-1:0] mix_average(
        input bit [dpsf_pkg::AVG_W-1:0] avg,
        input bit [dpsf_pkg::AVG_W-1:0] x,
        input bit [dpsf_pkg::WEIGHT_W-1:0] w_raw);
        bit [31:0] w;
        bit [31:0] acc;
        w = (w_raw > dpsf_pkg::WEIGHT_ONE) ? dpsf_pkg::WEIGHT_ONE : w_raw;
        acc = avg * (dpsf_pkg::WEIGHT_ONE - w) + x * w + 128;
        return dpsf_pkg::AVG_W'(acc >> 8);
    endfunction

    // expected result of one accepted sample; advances the shadow state
    function automatic dpsf_pkg::result_t filter_pixel(input bit [dpsf_pkg::DEPTH_W-1:0] d,
                                                       input bit [dpsf_pkg::IDX_W-1:0] idx);
        dpsf_pkg::result_t r;
        bit [dpsf_pkg::AVG_W-1:0] x, s, f, diff;
        bit [31:0] cnt;
        bit [31:0] rounded;
        bit chg, show;
        int key;
        key = idx;
        r = '0;
        r.norm_level = depth_to_level(d);
        if (idx >= dpsf_pkg::FRAME_PIXELS)
            return r;
        x = dpsf_pkg::AVG_W'(r.norm_level) << dpsf_pkg::FRAC_BITS;
        s = mix_average(slow_mem.exists(key) ? slow_mem[key] : '0, x, slow_w);
        f = mix_average(fast_mem.exists(key) ? fast_mem[key] : '0, x, fast_w);
        diff = (s > f) ? s - f : f - s;
        chg = diff > (dpsf_pkg::AVG_W'(thresh) << dpsf_pkg::FRAC_BITS);
        cnt = count_mem.exists(key) ? count_mem[key] : 0;
        if (chg)
        begin
            cnt = 0;
            s = x;
        end
        else if (cnt < stab_limit)
        begin
            cnt++;
        end
        cnt &= (1 << dpsf_pkg::CNT_W) - 1;
        show = (cnt + dpsf_pkg::SHOW_MARGIN) >= stab_limit;
        rounded = (s + (1 << (dpsf_pkg::FRAC_BITS - 1))) >> dpsf_pkg::FRAC_BITS;
        if (rounded > dpsf_pkg::LEVEL_MAX)
            rounded = dpsf_pkg::LEVEL_MAX;
        if (show)
            held_mem[key] = dpsf_pkg::LEVEL_W'(rounded);
        slow_mem[key] = s;
        fast_mem[key] = f;
        count_mem[key] = dpsf_pkg::CNT_W'(cnt);
        r.changing = chg;
        r.stable_frames = dpsf_pkg::CNT_W'(cnt);
        r.shown = show;
        r.final_level = held_mem.exists(key) ? held_mem[key] : '0;
        return r;
    endfunction

    // one sample transaction; entered and left at a falling edge
    task automatic send_pixel(input bit [dpsf_pkg::DEPTH_W-1:0] d,
                              input bit [dpsf_pkg::IDX_W-1:0] idx);
        dpsf_pkg::result_t r;
        sample.valid       <= 1'b1;
        sample.depth_mm    <= d;
        sample.pixel_index <= idx;
        do
            @(posedge clk);
        while (!sample.ready);
        r = filter_pixel(d, idx);
        pending_results.insert(pending_results.size(), r);
        sent_count++;
        if (r.changing) changing_seen++;
        if (r.shown) shown_seen++;
        if (idx >= dpsf_pkg::FRAME_PIXELS) outside_seen++;
        @(negedge clk);
        // bursts of random length separated by idle gaps
        if (!no_gaps)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                sample.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(0, 20);
            end
        end
    endtask

    // let every outstanding transaction retire before touching config
    task automatic wait_idle();
        sample.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [dpsf_pkg::CFG_IDX_W-1:0] which,
                             input bit [dpsf_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (which)
            dpsf_pkg::REG_DEPTH_MIN:        range_lo   = value[dpsf_pkg::DEPTH_W-1:0];
            dpsf_pkg::REG_DEPTH_MAX:        range_hi   = value[dpsf_pkg::DEPTH_W-1:0];
            dpsf_pkg::REG_SLOW_WEIGHT:      slow_w     = value[dpsf_pkg::WEIGHT_W-1:0];
            dpsf_pkg::REG_FAST_WEIGHT:      fast_w     = value[dpsf_pkg::WEIGHT_W-1:0];
            dpsf_pkg::REG_CHANGE_THRESHOLD: thresh     = value[dpsf_pkg::THR_W-1:0];
            dpsf_pkg::REG_MIN_STABILITY:    stab_limit = value[dpsf_pkg::CNT_W-1:0];
            default: ;  // unmapped index, nothing changes
        endcase
    endtask

    task automatic load_config(input bit [15:0] lo, input bit [15:0] hi, input bit [15:0] sw,
                               input bit [15:0] fw, input bit [15:0] th, input bit [15:0] ms);
        write_reg(dpsf_pkg::REG_DEPTH_MIN, lo);
        write_reg(dpsf_pkg::REG_DEPTH_MAX, hi);
        write_reg(dpsf_pkg::REG_SLOW_WEIGHT, sw);
        write_reg(dpsf_pkg::REG_FAST_WEIGHT, fw);
        write_reg(dpsf_pkg::REG_CHANGE_THRESHOLD, th);
        write_reg(dpsf_pkg::REG_MIN_STABILITY, ms);
    endtask

    // field extremes and the special cases under reset defaults
    task automatic test_directed_cases();
        send_pixel(16'd0, 19'd0);                                // below range
        send_pixel(16'd500, 19'd1);                              // bottom edge, level zero
        send_pixel(16'd501, 19'd1);
        send_pixel(16'd750, 19'd2);                              // mid range
        send_pixel(16'd999, 19'd3);
        send_pixel(16'd1000, 19'd3);                             // top edge, level zero
        send_pixel(16'd1001, 19'd4);                             // just above range
        send_pixel(16'hFFFF, 19'(dpsf_pkg::FRAME_PIXELS - 1));   // last pixel in frame
        send_pixel(16'd600, 19'(dpsf_pkg::FRAME_PIXELS));        // first index past the frame
        send_pixel(16'd600, 19'(IDX_SPAN - 1));                  // all index bits set
        // same pixel back to back, settles and climbs to the limit
        repeat (20) send_pixel(16'd520, 19'd7);
        wait_idle();
        // unmapped register index must not disturb anything
        write_reg(REG_UNUSED, 16'hFFFF);
        send_pixel(16'd520, 19'd7);
        wait_idle();
    endtask

    // settings including weights above one, empty range and tiny limits
    task automatic test_config_extremes();
        load_config(16'd0, 16'hFFFF, 16'd256, 16'd511, 16'd0, 16'd1023);
        for (int i = 0; i < 12; i++)
            send_pixel(16'($urandom_range(0, 65535)), 19'($urandom_range(0, 7)));
        wait_idle();
        load_config(16'd800, 16'd800, 16'd0, 16'd0, 16'd255, 16'd0);   // empty range
        for (int i = 0; i < 8; i++)
            send_pixel(16'($urandom_range(700, 900)), 19'($urandom_range(0, 7)));
        wait_idle();
        // lowered limit below counts already reached
        load_config(16'd500, 16'd1000, 16'd13, 16'd205, 16'd1, 16'd20);
        repeat (24) send_pixel(16'd700, 19'd9);
        wait_idle();
        write_reg(dpsf_pkg::REG_MIN_STABILITY, 16'd2);
        repeat (4) send_pixel(16'd700, 19'd9);
        wait_idle();
        write_reg(dpsf_pkg::REG_MIN_STABILITY, 16'd1);
        repeat (3) send_pixel(16'd700, 19'd10);
        wait_idle();
    endtask

    // mostly steady pixels with noise, some far-off samples and indexes
    task automatic test_random_stream(input int items);
        bit [dpsf_pkg::DEPTH_W-1:0] base [8];
        bit [dpsf_pkg::DEPTH_W-1:0] d;
        int p;
        for (int i = 0; i < 8; i++)
            base[i] = 16'($urandom_range(range_lo, range_hi));
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                p = $urandom_range(0, 7);
                if ($urandom_range(0, 19) == 0)
                    base[p] = 16'($urandom_range(range_lo, range_hi));
                d = base[p] + 16'($urandom_range(0, 4)) - 16'd2;
                send_pixel(d, 19'(p * 37 + 100));
            end
            else
            begin
                send_pixel(16'($urandom_range(0, 65535)), 19'($urandom_range(0, IDX_SPAN - 1)));
            end
        end
        wait_idle();
    endtask

    task automatic test_random_settings();
        bit [15:0] lo, hi;
        test_random_stream(200);
        for (int round = 0; round < 4; round++)
        begin
            lo = 16'($urandom_range(0, 40000));
            hi = lo + 16'($urandom_range(1, 20000));
            load_config(lo, hi, 16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                        16'($urandom_range(0, 6)), 16'($urandom_range(0, 30)));
            test_random_stream(180);
        end
    endtask

    // receiver holds off long enough to fill the pipe and stall the input
    task automatic test_backpressure();
        load_config(16'd500, 16'd1000, 16'd13, 16'd205, 16'd1, 16'd15);
        hold_cycles = 120;
        no_gaps = 1'b1;
        for (int i = 0; i < 60; i++)
            send_pixel(16'($urandom_range(500, 1000)), 19'($urandom_range(0, 3)));
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // receiver: own stall pattern, plus the long hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            result.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 80);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: result.ready <= 1'b1;                              // no stalls
                1: result.ready <= ($urandom_range(0, 9) > 2);        // random stalls
                default: result.ready <= (mode_left % 3 != 0);        // periodic stalls
            endcase
        end
    end

    // result checker, compares in order against the expected queue
    always @(posedge clk)
    begin
        dpsf_pkg::result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (result.norm_level !== want.norm_level)
                begin
                    $error("norm_level expected %0d actual %0d", want.norm_level,
                           result.norm_level);
                    error_count++;
                end
                if (result.changing !== want.changing)
                begin
                    $error("changing expected %0d actual %0d", want.changing, result.changing);
                    error_count++;
                end
                if (result.stable_frames !== want.stable_frames)
                begin
                    $error("stable_frames expected %0d actual %0d", want.stable_frames,
                           result.stable_frames);
                    error_count++;
                end
                if (result.shown !== want.shown)
                begin
                    $error("shown expected %0d actual %0d", want.shown, result.shown);
                    error_count++;
                end
                if (result.final_level !== want.final_level)
                begin
                    $error("final_level expected %0d actual %0d", want.final_level,
                           result.final_level);
                    error_count++;
                end
            end
        end
    end

    // watchdog, covers the clear pass after reset and a slow stalled run
    initial
    begin
        #20_000_000;
        $display("depth_pixel_stability_filter_unit verification failed");
        $finish;
    end

    initial
    begin
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        changing_seen = 0;
        shown_seen = 0;
        outside_seen = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        hold_cycles = 0;
        stall_mode = 0;
        mode_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample.valid = 1'b0;
        sample.depth_mm = '0;
        sample.pixel_index = '0;
        result.ready = 1'b0;
        // reset defaults of the shadow config
        range_lo = 16'd500;
        range_hi = 16'd1000;
        slow_w = 9'd13;
        fast_w = 9'd205;
        thresh = 8'd1;
        stab_limit = 10'd15;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_config_extremes();
        test_random_settings();
        test_backpressure();

        wait_idle();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("covered %0d samples, %0d checked: %0d changing, %0d shown, %0d out of frame",
                 sent_count, checked_count, changing_seen, shown_seen, outside_seen);
        $display("config sweeps included empty range, weights above one and tiny limits");
        if (error_count == 0)
            $display("depth_pixel_stability_filter_unit verification clean");
        else
            $display("depth_pixel_stability_filter_unit verification failed");
        $finish;
    end

endmodule

@@ depth_pixel_stability_filter_unit.f @@
+incdir+design
design/dpsf_pkg.sv
design/dpsf_if.sv
design/dpsf_ram.sv
design/dpsf_norm.sv
design/dpsf_update.sv
design/depth_pixel_stability_filter_unit.sv
dv/depth_pixel_stability_filter_unit_test.sv
